// ===== src/multi_channel_message_fifo_top_macros.svh =====
// Assertion macros for the message mailbox.
// Used by the top level; no other dependencies.
`ifndef MULTI_CHANNEL_MESSAGE_FIFO_TOP_MACROS_SVH
`define MULTI_CHANNEL_MESSAGE_FIFO_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MCMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MCMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/mcmf_pkg.sv =====
// Shared types and constants for the message mailbox.
// No dependencies.
`default_nettype none

package mcmf_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CHAN_DEPTH   = 16;
    localparam int WORD_BITS    = 32;

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SLOT_W = (CHAN_DEPTH > 1) ? $clog2(CHAN_DEPTH) : 1;
    localparam int FILL_W = $clog2(CHAN_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_OPEN  = 3'd0,
        OP_CLOSE = 3'd1,
        OP_SEND  = 3'd2,
        OP_RECV  = 3'd3,
        OP_BCAST = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_CHAN = 2'd1,
        ST_BLOCK   = 2'd2,
        ST_NO_FREE = 2'd3
    } status_t;

    typedef struct packed {
        op_t         opcode;
        logic [2:0]  chan_index;
        logic [31:0] write_word;
        logic [4:0]  capacity_req;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  opened_index;
        logic [31:0] read_word;
    } rsp_t;

    // Bank access for one item.
    typedef struct packed {
        logic [NUM_CHANNELS-1:0]             wr_en;
        logic [NUM_CHANNELS-1:0][SLOT_W-1:0] wr_slot;
        logic [WORD_BITS-1:0]                wr_word;
        logic [NUM_CHANNELS-1:0]             rd_en;
        logic [SLOT_W-1:0]                   rd_slot;
    } mem_req_t;

    // Result fields before the bank read data is attached.
    typedef struct packed {
        status_t     status;
        logic [2:0]  opened_index;
        logic        rd_hit;
        logic [CH_W-1:0] rd_chan;
    } result_t;

endpackage

`default_nettype wire

// ===== src/multi_channel_message_fifo_top.sv =====
// A result is valid in the cycle after its request word is accepted.
// Throughput: one word per cycle; the channel state updates in a single pass and the
// per-channel banks take one write and one registered read per cycle.
// A stalled result holds the request side (req_stall follows rsp_stall combinationally).
// Reset clears all channel state at once; the word banks are not cleared.
`default_nettype none

`include "multi_channel_message_fifo_top_macros.svh"

module multi_channel_message_fifo_top
    import mcmf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic     accept;
    mem_req_t mem_req;
    result_t  result;
    result_t  result_reg;
    logic     rsp_valid_reg, rsp_valid_next;

    logic [NUM_CHANNELS-1:0][WORD_BITS-1:0] bank_word;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    mcmf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .req     (req),
        .mem_req (mem_req),
        .result  (result)
    );

    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_bank
        mcmf_bank u_bank (
            .clk     (clk),
            .wr_en   (mem_req.wr_en[c]),
            .wr_slot (mem_req.wr_slot[c]),
            .wr_word (mem_req.wr_word),
            .rd_en   (mem_req.rd_en[c]),
            .rd_slot (mem_req.rd_slot),
            .rd_word (bank_word[c])
        );
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign rsp.status       = result_reg.status;
    assign rsp.opened_index = result_reg.opened_index;
    assign rsp.read_word    = result_reg.rd_hit ? 32'(bank_word[result_reg.rd_chan]) : 32'd0;

    `MCMF_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, rsp_valid)
    `MCMF_ASSERT_NOW(a_single_read, clk, rst_n, 1'b1, $onehot0(mem_req.rd_en))
    `MCMF_ASSERT_NOW(a_read_needs_ok, clk, rst_n,
                     rsp_valid && (rsp.status != ST_OK), rsp.read_word == 32'd0)
    `MCMF_ASSERT_NOW(a_open_needs_ok, clk, rst_n,
                     rsp_valid && (rsp.opened_index != 3'd0), rsp.status == ST_OK)

endmodule

`default_nettype wire

// ===== src/mcmf_bank.sv =====
// Word storage for one channel: one write port, one registered read port.
// Depends on mcmf_pkg.
`default_nettype none

module mcmf_bank
    import mcmf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [SLOT_W-1:0]    wr_slot,
    input  wire logic [WORD_BITS-1:0] wr_word,
    input  wire logic                 rd_en,
    input  wire logic [SLOT_W-1:0]    rd_slot,
    output logic      [WORD_BITS-1:0] rd_word
);

    logic [WORD_BITS-1:0] mem [CHAN_DEPTH];
    logic [WORD_BITS-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_word;
        end
        // hold the read word until the next receive on this channel
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_slot];
        end
    end

    assign rd_word = rd_word_reg;

endmodule

`default_nettype wire

// ===== src/mcmf_ctrl.sv =====
// Channel bookkeeping: open flags, limits, fill counts and ring pointers.
// Decodes one request per cycle into a result and bank accesses. Depends on mcmf_pkg.
`default_nettype none

module mcmf_ctrl
    import mcmf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire req_t     req,
    output mem_req_t      mem_req,
    output result_t       result
);

    logic [NUM_CHANNELS-1:0]             open_reg,  open_next;
    logic [NUM_CHANNELS-1:0][FILL_W-1:0] limit_reg, limit_next;
    logic [NUM_CHANNELS-1:0][FILL_W-1:0] fill_reg,  fill_next;
    logic [NUM_CHANNELS-1:0][SLOT_W-1:0] head_reg,  head_next;
    logic [NUM_CHANNELS-1:0][SLOT_W-1:0] tail_reg,  tail_next;

    logic [NUM_CHANNELS-1:0] full;
    logic                    free_found;
    logic [CH_W-1:0]         free_idx;
    logic                    any_open;
    logic                    blocked;
    logic                    chan_ok;
    logic [CH_W-1:0]         cidx;
    logic [FILL_W-1:0]       cap_sat;

    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(CHAN_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    assign cidx     = CH_W'(req.chan_index);
    assign chan_ok  = (32'(req.chan_index) < NUM_CHANNELS) && open_reg[cidx];
    assign any_open = |open_reg;
    assign blocked  = |(open_reg & full);
    assign cap_sat  = (32'(req.capacity_req) > CHAN_DEPTH) ? FILL_W'(CHAN_DEPTH)
                                                           : FILL_W'(req.capacity_req);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        // scan downward so the lowest closed channel wins
        for (int c = NUM_CHANNELS - 1; c >= 0; c--)
        begin
            full[c] = fill_reg[c] >= limit_reg[c];
            if (!open_reg[c])
            begin
                free_found = 1'b1;
                free_idx   = CH_W'(c);
            end
        end
    end

    always_comb
    begin
        open_next  = open_reg;
        limit_next = limit_reg;
        fill_next  = fill_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;

        mem_req.wr_en   = '0;
        mem_req.wr_slot = tail_reg;
        mem_req.wr_word = WORD_BITS'(req.write_word);
        mem_req.rd_en   = '0;
        mem_req.rd_slot = head_reg[cidx];

        result.status       = ST_NO_CHAN;
        result.opened_index = '0;
        result.rd_hit       = 1'b0;
        result.rd_chan      = cidx;

        case (req.opcode)
            OP_OPEN:
            begin
                if (free_found)
                begin
                    result.status       = ST_OK;
                    result.opened_index = 3'(free_idx);
                    if (accept)
                    begin
                        open_next[free_idx]  = 1'b1;
                        limit_next[free_idx] = cap_sat;
                        fill_next[free_idx]  = '0;
                        head_next[free_idx]  = '0;
                        tail_next[free_idx]  = '0;
                    end
                end
                else
                begin
                    result.status = ST_NO_FREE;
                end
            end
            OP_CLOSE:
            begin
                if (chan_ok)
                begin
                    result.status = ST_OK;
                    if (accept)
                    begin
                        open_next[cidx]  = 1'b0;
                        limit_next[cidx] = '0;
                        fill_next[cidx]  = '0;
                        head_next[cidx]  = '0;
                        tail_next[cidx]  = '0;
                    end
                end
            end
            OP_SEND:
            begin
                if (chan_ok)
                begin
                    if (full[cidx])
                    begin
                        result.status = ST_BLOCK;
                    end
                    else
                    begin
                        result.status = ST_OK;
                        if (accept)
                        begin
                            mem_req.wr_en[cidx] = 1'b1;
                            tail_next[cidx]     = slot_next(tail_reg[cidx]);
                            fill_next[cidx]     = fill_reg[cidx] + FILL_W'(1);
                        end
                    end
                end
            end
            OP_RECV:
            begin
                if (chan_ok)
                begin
                    if (fill_reg[cidx] == '0)
                    begin
                        result.status = ST_BLOCK;
                    end
                    else
                    begin
                        result.status = ST_OK;
                        result.rd_hit = 1'b1;
                        if (accept)
                        begin
                            mem_req.rd_en[cidx] = 1'b1;
                            head_next[cidx]     = slot_next(head_reg[cidx]);
                            fill_next[cidx]     = fill_reg[cidx] - FILL_W'(1);
                        end
                    end
                end
            end
            OP_BCAST:
            begin
                if (!any_open)
                begin
                    result.status = ST_NO_CHAN;
                end
                else if (blocked)
                begin
                    result.status = ST_BLOCK;
                end
                else
                begin
                    result.status = ST_OK;
                    if (accept)
                    begin
                        mem_req.wr_en = open_reg;
                        for (int c = 0; c < NUM_CHANNELS; c++)
                        begin
                            if (open_reg[c])
                            begin
                                tail_next[c] = slot_next(tail_reg[c]);
                                fill_next[c] = fill_reg[c] + FILL_W'(1);
                            end
                        end
                    end
                end
            end
            default:
            begin
                result.status = ST_NO_CHAN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= '0;
            limit_reg <= '0;
            fill_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            open_reg  <= open_next;
            limit_reg <= limit_next;
            fill_reg  <= fill_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/chan_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the message mailbox: tracks channel state and predicts each reply word.
// Depends on mcmf_pkg for the request and reply types.

package chan_scoreboard_pkg;

    import mcmf_pkg::*;

    class chan_scoreboard;

        bit                     live   [NUM_CHANNELS];
        logic [FILL_W-1:0]      limit  [NUM_CHANNELS];
        logic [FILL_W-1:0]      fill   [NUM_CHANNELS];
        logic [SLOT_W-1:0]      head   [NUM_CHANNELS];
        logic [SLOT_W-1:0]      tail   [NUM_CHANNELS];
        logic [WORD_BITS-1:0]   words  [NUM_CHANNELS][CHAN_DEPTH];
        rsp_t                   replies_due[$];
        int unsigned            errors;

        function new();
            errors = 0;
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                drop_channel(k);
            end
        endfunction

        function void drop_channel(int k);
            live[k]  = 1'b0;
            limit[k] = '0;
            fill[k]  = '0;
            head[k]  = '0;
            tail[k]  = '0;
        endfunction

        function logic [SLOT_W-1:0] slot_next(logic [SLOT_W-1:0] s);
            return (int'(s) >= CHAN_DEPTH - 1) ? '0 : s + 1'b1;
        endfunction

        function void push_word(int k, logic [31:0] w);
            words[k][tail[k]] = w[WORD_BITS-1:0];
            tail[k] = slot_next(tail[k]);
            fill[k] = fill[k] + 1'b1;
        endfunction

        function bit is_full(int k);
            return fill[k] >= limit[k];
        endfunction

        function bit is_open(int k);
            return live[k];
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        // Apply one accepted request word and queue the reply it must produce.
        function void take_request(req_t r);
            rsp_t e;
            int   c;
            bit   chan_ok;
            bit   any_open;
            bit   any_full;
            e = '0;
            e.status = ST_NO_CHAN;
            c = int'(r.chan_index);
            chan_ok = (c < NUM_CHANNELS) && live[c];
            any_open = 1'b0;
            any_full = 1'b0;
            case (r.opcode)
                OP_OPEN:
                begin
                    e.status = ST_NO_FREE;
                    for (int k = 0; k < NUM_CHANNELS; k++)
                    begin
                        if (!live[k])
                        begin
                            drop_channel(k);
                            live[k] = 1'b1;
                            limit[k] = (int'(r.capacity_req) > CHAN_DEPTH) ?
                                       FILL_W'(CHAN_DEPTH) : FILL_W'(r.capacity_req);
                            e.opened_index = 3'(k);
                            e.status = ST_OK;
                            break;
                        end
                    end
                end
                OP_CLOSE:
                begin
                    if (chan_ok)
                    begin
                        drop_channel(c);
                        e.status = ST_OK;
                    end
                end
                OP_SEND:
                begin
                    if (chan_ok)
                    begin
                        if (is_full(c))
                            e.status = ST_BLOCK;
                        else
                        begin
                            push_word(c, r.write_word);
                            e.status = ST_OK;
                        end
                    end
                end
                OP_RECV:
                begin
                    if (chan_ok)
                    begin
                        if (fill[c] == '0)
                            e.status = ST_BLOCK;
                        else
                        begin
                            e.read_word = 32'(words[c][head[c]]);
                            head[c] = slot_next(head[c]);
                            fill[c] = fill[c] - 1'b1;
                            e.status = ST_OK;
                        end
                    end
                end
                OP_BCAST:
                begin
                    for (int k = 0; k < NUM_CHANNELS; k++)
                    begin
                        if (live[k])
                        begin
                            any_open = 1'b1;
                            if (is_full(k))
                                any_full = 1'b1;
                        end
                    end
                    // all or nothing: one full channel blocks every channel
                    if (!any_open)
                        e.status = ST_NO_CHAN;
                    else if (any_full)
                        e.status = ST_BLOCK;
                    else
                    begin
                        for (int k = 0; k < NUM_CHANNELS; k++)
                        begin
                            if (live[k])
                                push_word(k, r.write_word);
                        end
                        e.status = ST_OK;
                    end
                end
                default:
                begin
                    e.status = ST_NO_CHAN;
                end
            endcase
            replies_due.push_back(e);
        endfunction

        function void check_reply(rsp_t got);
            rsp_t want;
            if (replies_due.size() == 0)
            begin
                $error("reply word with no request pending: status %0d", got.status);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.opened_index !== want.opened_index)
            begin
                $error("opened_index: expected %0d, got %0d",
                       want.opened_index, got.opened_index);
                errors++;
            end
            if (got.read_word !== want.read_word)
            begin
                $error("read_word: expected 0x%08h, got 0x%08h",
                       want.read_word, got.read_word);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top-level mailbox bench: directed and random requests with idling and reply stalls.
// Depends on mcmf_pkg, chan_scoreboard_pkg and multi_channel_message_fifo_top.

module tb_top;

    import mcmf_pkg::*;
    import chan_scoreboard_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic req_taken = 1'b0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;

    chan_scoreboard sb;

    multi_channel_message_fifo_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Check the reply before noting the request: a reply never answers the word taken
    // at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_reply(rsp);
            if (req_valid && !req_stall)
                sb.take_request(req);
        end
        req_taken <= rst_n && req_valid && !req_stall;
    end

    task automatic send_word(input req_t r);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(negedge clk);
        while (!req_taken)
            @(negedge clk);
    endtask

    task automatic issue(input op_t op, input int ch, input logic [31:0] w, input int cap);
        req_t r;
        r.opcode       = op;
        r.chan_index   = 3'(ch);
        r.write_word   = w;
        r.capacity_req = 5'(cap);
        send_word(r);
    endtask

    // Hold the sender until every reply has come back.
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic req_t random_request(int send_bias);
        req_t r;
        int   pick;
        int   k;
        int   open_chans[$];
        r.write_word = $urandom();
        r.chan_index = 3'($urandom_range(7));
        k = $urandom_range(9);
        if (k == 0)
            r.capacity_req = 5'd0;
        else if (k == 1)
            r.capacity_req = 5'($urandom_range(31, 17));
        else if (k < 6)
            r.capacity_req = 5'($urandom_range(6, 1));
        else
            r.capacity_req = 5'($urandom_range(16, 7));
        pick = $urandom_range(99);
        if (pick < 3)
            r.opcode = op_t'($urandom_range(7, 5));
        else if (pick < 15)
            r.opcode = OP_OPEN;
        else if (pick < 21)
            r.opcode = OP_CLOSE;
        else if (pick < 21 + send_bias)
            r.opcode = OP_SEND;
        else if (pick < 88)
            r.opcode = OP_RECV;
        else
            r.opcode = OP_BCAST;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (sb.is_open(c))
                open_chans.push_back(c);
        end
        // aim mostly at live channels, now and then at a closed one
        if (open_chans.size() != 0 && $urandom_range(9) != 0)
            r.chan_index = 3'(open_chans[$urandom_range(open_chans.size() - 1)]);
        return r;
    endfunction

    task automatic run_random(input int count);
        int bias;
        bias = 40;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
                bias = $urandom_range(55, 25);
            send_word(random_request(bias));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // nothing open yet
        issue(OP_BCAST, 0, 32'h1234_5678, 0);
        issue(OP_RECV, 0, 32'h0, 0);
        issue(OP_SEND, 3, 32'hDEAD_BEEF, 0);
        issue(OP_CLOSE, 7, 32'h0, 0);
        issue(op_t'(3'd5), 2, 32'hFFFF_FFFF, 31);
        issue(op_t'(3'd6), 5, 32'h0, 16);
        issue(op_t'(3'd7), 7, 32'hAAAA_5555, 1);
        // zero capacity, oversized capacity, capacity of one
        issue(OP_OPEN, 0, 32'h0, 0);
        issue(OP_SEND, 0, 32'h0000_0001, 0);
        issue(OP_OPEN, 0, 32'h0, 31);
        issue(OP_OPEN, 0, 32'h0, 1);
        issue(OP_RECV, 2, 32'h0, 0);
        issue(OP_BCAST, 0, 32'hFFFF_FFFF, 0);
        issue(OP_CLOSE, 0, 32'h0, 0);
        issue(OP_BCAST, 0, 32'hFFFF_FFFF, 0);
        issue(OP_SEND, 2, 32'h5555_AAAA, 0);
        issue(OP_BCAST, 0, 32'h0000_0000, 0);
        issue(OP_RECV, 2, 32'h0, 0);
        issue(OP_RECV, 1, 32'h0, 0);
        // open every channel, then one more open
        issue(OP_OPEN, 0, 32'h0, 16);
        for (int c = 3; c < NUM_CHANNELS; c++)
        begin
            issue(OP_OPEN, 0, 32'h0, $urandom_range(16, 1));
        end
        issue(OP_OPEN, 0, 32'h0, 8);
        issue(OP_SEND, 7, 32'h0, 0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 68;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 68;
                end
                default:
                begin
                    send_idle_pct = 14;
                    stall_pct = 14;
                end
            endcase
            for (int blk = 0; blk < 3; blk++)
            begin
                run_random(50);
                drain();
            end
        end

        send_idle_pct = 0;
        stall_pct = 0;
        drain();
        repeat (4) @(negedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/mcmf_pkg.sv
src/mcmf_bank.sv
src/mcmf_ctrl.sv
src/multi_channel_message_fifo_top.sv
tb/sv/chan_scoreboard_pkg.sv
tb/sv/tb_top.sv
